// ----- rtl/core/cbcp_pkg.sv -----
// Package: shared types, constants and calibration tables for cluster box and projection.
`timescale 1ns / 1ps
package cbcp_pkg;

  localparam int CoordFracBits = 8;
  localparam int SumShift = CoordFracBits + 1;
  localparam logic signed [16:0] OneM = 17'(1 << CoordFracBits);
  localparam logic signed [16:0] SixTenthsM = 17'((6 * (1 << CoordFracBits) + 5) / 10);

  localparam logic signed [21:0] Rot [3][3] = '{
    '{22'sd861, -22'sd1048567, 22'sd4302},
    '{-22'sd225405, -22'sd4386, -22'sd1024053},
    '{22'sd1024062, -22'sd84, -22'sd225407}
  };
  localparam logic signed [21:0] Trans [3] = '{-22'sd11069, 22'sd635612, 22'sd1448935};

  localparam logic signed [27:0] FocalU = 28'sd61620654;
  localparam logic signed [27:0] CenterU = 28'sd41893976;
  localparam logic signed [27:0] FocalV = 28'sd61238700;
  localparam logic signed [27:0] CenterV = 28'sd26312231;

  typedef struct packed {
    logic signed [15:0] least_x;
    logic signed [15:0] greatest_x;
    logic signed [15:0] least_y;
    logic signed [15:0] greatest_y;
    logic signed [15:0] least_z;
    logic signed [15:0] greatest_z;
    logic signed [15:0] y_at_least_x;
    logic signed [15:0] y_at_greatest_x;
  } box_t;

endpackage

// ----- rtl/core/cbcp_front.sv -----
// Front: running box extremes per point; pushes the finished box into the queue.
`timescale 1ns / 1ps
module cbcp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic signed [15:0]  point_x,
  input  logic signed [15:0]  point_y,
  input  logic signed [15:0]  point_z,
  input  logic                last_of_cluster,
  output logic                box_valid,
  input  logic                box_ready,
  output cbcp_pkg::box_t      box
);
  logic cluster_empty;
  cbcp_pkg::box_t acc, acc_next;
  logic full;

  assign ready = !full || box_ready;
  assign box_valid = full;

  always_comb begin
    acc_next = acc;
    if (cluster_empty) begin
      acc_next = '{point_x, point_x, point_y, point_y, point_z, point_z, point_y, point_y};
    end else begin
      if (point_x > acc.greatest_x) begin
        acc_next.greatest_x = point_x;
        acc_next.y_at_greatest_x = point_y;
      end
      if (point_x < acc.least_x) begin
        acc_next.least_x = point_x;
        acc_next.y_at_least_x = point_y;
      end
      if (point_y < acc.least_y) acc_next.least_y = point_y;
      if (point_y > acc.greatest_y) acc_next.greatest_y = point_y;
      if (point_z < acc.least_z) acc_next.least_z = point_z;
      if (point_z > acc.greatest_z) acc_next.greatest_z = point_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_empty <= 1'b1;
      full <= 1'b0;
      acc <= '0;
    end else begin
      if (valid && ready && last_of_cluster) full <= 1'b1;
      else if (box_ready) full <= 1'b0;
      if (valid && ready) begin
        acc <= acc_next;
        cluster_empty <= last_of_cluster;
        if (last_of_cluster) box <= acc_next;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !box_ready |-> !ready) else $error("front accepted while queue full");
  a_box_hold: assert property (@(posedge clk) disable iff (rst)
    full && !box_ready |=> full && $stable(box)) else $error("box changed while waiting");
  a_empty_after_last: assert property (@(posedge clk) disable iff (rst)
    valid && ready && last_of_cluster |=> cluster_empty) else $error("cluster not cleared");
`endif
endmodule

// ----- rtl/core/cbcp_divider.sv -----
// Restoring divider: unsigned 64/44 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
module cbcp_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [43:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [6:0] count;
  logic busy;
  logic [44:0] rem;
  logic [44:0] trial;

  assign trial = {rem[43:0], quotient[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == 7'd63);
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
        rem <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[44]) begin
          rem <= trial;
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem <= {rem[43:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd63) busy <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/core/cbcp_back.sv -----
// Back: box outputs, near/far adjust, camera projection via shared multipliers and divider.
`timescale 1ns / 1ps
module cbcp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                box_valid,
  output logic                box_ready,
  input  cbcp_pkg::box_t      box,
  output logic                valid,
  input  logic                ready,
  output logic signed [15:0]  center_x,
  output logic signed [15:0]  center_y,
  output logic signed [15:0]  center_z,
  output logic [15:0]         length_x,
  output logic [15:0]         length_y,
  output logic [15:0]         length_z,
  output logic signed [15:0]  near_x,
  output logic signed [15:0]  near_y,
  output logic signed [15:0]  far_x,
  output logic signed [15:0]  far_y,
  output logic signed [15:0]  pixel_u,
  output logic signed [15:0]  pixel_v
);
  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_SHIFT, S_NUM, S_DIVU, S_WAITU, S_DIVV, S_WAITV, S_OUT
  } state_t;
  state_t state;

  cbcp_pkg::box_t b;
  logic signed [16:0] s [3];
  logic [1:0] row, col;
  logic signed [41:0] acc;
  logic signed [28:0] q [3];
  logic signed [56:0] num_u, num_v;
  logic signed [38:0] prod;
  logic signed [55:0] fprod;
  logic [1:0] nstep;
  logic neg;
  logic div_start, div_done;
  logic [63:0] div_dividend, div_quot;
  logic [43:0] div_divisor;

  cbcp_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quot)
  );

  assign box_ready = (state == S_IDLE);
  assign prod = 39'(cbcp_pkg::Rot[row][col] * s[col]);

  function automatic logic signed [15:0] sat16(input logic signed [64:0] v);
    if (v > 65'sd32767) return 16'sh7fff;
    if (v < -65'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    unique case (nstep)
      2'd0: fprod = 56'(cbcp_pkg::FocalU * q[0]);
      2'd1: fprod = 56'(cbcp_pkg::CenterU * q[2]);
      2'd2: fprod = 56'(cbcp_pkg::FocalV * q[1]);
      default: fprod = 56'(cbcp_pkg::CenterV * q[2]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_DIVU && q[2] > 29'sd0) || state == S_DIVV;
      unique case (state)
        S_IDLE: if (box_valid) begin
          b <= box;
          s[0] <= 17'(box.least_x) + 17'(box.greatest_x);
          s[1] <= 17'(box.least_y) + 17'(box.greatest_y);
          s[2] <= 17'(box.least_z) + 17'(box.greatest_z);
          row <= 2'd0;
          col <= 2'd0;
          acc <= 42'(cbcp_pkg::Trans[0]) <<< cbcp_pkg::SumShift;
          state <= S_MAC;
        end
        S_MAC: begin
          acc <= acc + 42'(prod);
          if (col == 2'd2) begin
            col <= 2'd0;
            state <= S_SHIFT;
          end else col <= col + 2'd1;
        end
        S_SHIFT: begin
          q[row] <= 29'(acc >>> cbcp_pkg::SumShift);
          if (row == 2'd2) begin
            nstep <= 2'd0;
            state <= S_NUM;
          end else begin
            row <= row + 2'd1;
            acc <= 42'(cbcp_pkg::Trans[row + 2'd1]) <<< cbcp_pkg::SumShift;
            state <= S_MAC;
          end
        end
        S_NUM: begin
          unique case (nstep)
            2'd0: num_u <= 57'(fprod);
            2'd1: num_u <= num_u + 57'(fprod);
            2'd2: num_v <= 57'(fprod);
            default: num_v <= num_v + 57'(fprod);
          endcase
          nstep <= nstep + 2'd1;
          if (nstep == 2'd3) state <= S_DIVU;
        end
        S_DIVU: begin
          if (q[2] <= 29'sd0) begin
            pixel_u <= 16'sh8000;
            pixel_v <= 16'sh8000;
            state <= S_OUT;
          end else begin
            neg <= num_u[56];
            div_dividend <= 64'(num_u[56] ? -num_u : num_u);
            div_divisor <= {q[2][27:0], 16'd0};
            state <= S_WAITU;
          end
        end
        S_WAITU: if (div_done) begin
          pixel_u <= sat16(neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot}));
          state <= S_DIVV;
        end
        S_DIVV: begin
          neg <= num_v[56];
          div_dividend <= 64'(num_v[56] ? -num_v : num_v);
          state <= S_WAITV;
        end
        S_WAITV: if (div_done) begin
          pixel_v <= sat16(neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot}));
          state <= S_OUT;
        end
        S_OUT: begin
          center_x <= 16'(s[0] >>> 1);
          center_y <= 16'(s[1] >>> 1);
          center_z <= 16'(s[2] >>> 1);
          length_x <= 16'(b.greatest_x - b.least_x);
          length_y <= 16'(b.greatest_y - b.least_y);
          length_z <= 16'(b.greatest_z - b.least_z);
          near_x <= b.least_x;
          far_x <= b.greatest_x;
          near_y <= (17'(b.y_at_least_x) - 17'(b.least_y) < cbcp_pkg::OneM)
            ? sat16(65'(b.least_y) + 65'(cbcp_pkg::SixTenthsM)) : b.y_at_least_x;
          far_y <= (17'(b.greatest_y) - 17'(b.y_at_greatest_x) < cbcp_pkg::OneM)
            ? sat16(65'(b.greatest_y) - 65'(cbcp_pkg::SixTenthsM)) : b.y_at_greatest_x;
          valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (valid && ready && state != S_OUT) valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    box_ready |-> state == S_IDLE) else $error("queue popped while busy");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(center_x) && $stable(pixel_u))
    else $error("result changed while stalled");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> row != 2'd3 && col != 2'd3) else $error("index range");
`endif
endmodule

// ----- rtl/core/cluster_box_and_camera_projection.sv -----
// Top level: cluster box extremes and camera projection of the box center.
`timescale 1ns / 1ps
// Points are taken one per cycle unless a finished box is stuck in the queue; a point marked
// last hands its box through a one-entry queue to the back end, which computes outputs using
// 9 multiply steps, 4 numerator products and up to two 64-step serial divisions. Meanwhile
// the next cluster's points keep flowing until a second finished box waits for the back end.
module cluster_box_and_camera_projection (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  point_x,
  input  logic signed [15:0]  point_y,
  input  logic signed [15:0]  point_z,
  input  logic                last_of_cluster,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  center_x,
  output logic signed [15:0]  center_y,
  output logic signed [15:0]  center_z,
  output logic [15:0]         length_x,
  output logic [15:0]         length_y,
  output logic [15:0]         length_z,
  output logic signed [15:0]  near_x,
  output logic signed [15:0]  near_y,
  output logic signed [15:0]  far_x,
  output logic signed [15:0]  far_y,
  output logic signed [15:0]  pixel_u,
  output logic signed [15:0]  pixel_v
);
  logic bv, br, back_idle;
  cbcp_pkg::box_t box;

  cbcp_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready), .point_x(point_x),
    .point_y(point_y), .point_z(point_z), .last_of_cluster(last_of_cluster),
    .box_valid(bv), .box_ready(back_idle), .box(box)
  );

  assign back_idle = br && !(out_valid && !out_ready);

  cbcp_back u_back (
    .clk(clk), .rst(rst), .box_valid(bv && back_idle), .box_ready(br), .box(box),
    .valid(out_valid), .ready(out_ready),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .length_x(length_x), .length_y(length_y), .length_z(length_z),
    .near_x(near_x), .near_y(near_y), .far_x(far_x), .far_y(far_y),
    .pixel_u(pixel_u), .pixel_v(pixel_v)
  );
endmodule
